>>> rtl/gvp_pkg.sv
`timescale 1ns / 1ps

package gvp_pkg;

    // Default depth of the ARCH and GARCH lag stores.
    localparam int MAX_ARCH_ORDER_DEF  = 2;
    localparam int MAX_GARCH_ORDER_DEF = 2;

    // Field widths fixed by the item formats.
    localparam int DATA_W     = 32;
    localparam int WEIGHT_W   = 16;
    localparam int ORDER_W    = 2;
    localparam int CFG_IDX_W  = 3;

    // Digit-serial multiply-accumulate unit.
    localparam int MAC_ACC_W  = 64;
    localparam int MAC_DIG_W  = 4;

    // Bit-serial square root of variance * 2^16.
    localparam int SQ_IN_W    = 48;
    localparam int SQ_ROOT_W  = SQ_IN_W / 2;
    localparam int SQ_REM_W   = SQ_ROOT_W + 3;
    localparam int SQ_CNT_W   = $clog2(SQ_ROOT_W + 1);

    // Rounding offsets preloaded into the accumulator.
    localparam logic [15:0]          VAR_ROUND = 16'h8000;
    localparam logic [MAC_ACC_W-1:0] RES_ROUND = MAC_ACC_W'(64'h0000_0000_0080_0000);
    localparam logic [MAC_ACC_W-1:0] SQR_ROUND = MAC_ACC_W'(64'h0000_0000_0000_8000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARCH_ORDER  = 3'd0,
        CFG_GARCH_ORDER = 3'd1,
        CFG_ALPHA_LAG1  = 3'd2,
        CFG_ALPHA_LAG2  = 3'd3,
        CFG_BETA_LAG1   = 3'd4,
        CFG_BETA_LAG2   = 3'd5,
        CFG_MEAN_LEVEL  = 3'd6
    } t_cfg_index;

    typedef enum logic {
        CMD_PRELOAD = 1'b0,
        CMD_STEP    = 1'b1
    } t_cmd;

    typedef struct packed {
        logic                     cmd;
        logic                     lag_slot;
        logic [DATA_W-1:0]        seed_residual_sq;
        logic [DATA_W-1:0]        seed_variance;
        logic signed [DATA_W-1:0] shock;
        logic [DATA_W-1:0]        intercept;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0]        variance;
        logic [DATA_W-1:0]        sigma;
        logic signed [DATA_W-1:0] residual;
        logic signed [DATA_W-1:0] series;
    } t_out_item;

endpackage

>>> rtl/garch_variance_path_step.sv
// A preload request is taken while idle and leaves the block idle. A step request
// runs through the 4-bit digit-serial multiply-accumulate unit and the 24-step serial
// square root before its result reaches the output register; a result held by the
// receiver delays the hand-over.
// One request is in flight at a time; the next is taken the cycle after the result
// is in the output register. Reset is synchronous and active low.
`timescale 1ns / 1ps

module garch_variance_path_step #(
    parameter int MAX_ARCH_ORDER  = gvp_pkg::MAX_ARCH_ORDER_DEF,
    parameter int MAX_GARCH_ORDER = gvp_pkg::MAX_GARCH_ORDER_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input requests: preload a lag slot or simulate one step.
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  gvp_pkg::t_in_item                   i_in,
    // Results, one per step request.
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output gvp_pkg::t_out_item                  o_out,
    // Register writes.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gvp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gvp_pkg::DATA_W-1:0]          i_cfg_data
);

    localparam int DW  = gvp_pkg::DATA_W;
    localparam int WW  = gvp_pkg::WEIGHT_W;
    localparam int AW  = gvp_pkg::MAC_ACC_W;
    // Lag counters must be able to hold the order itself.
    localparam int AJW = $clog2(MAX_ARCH_ORDER + 1);
    localparam int GJW = $clog2(MAX_GARCH_ORDER + 1);
    localparam int AIW = (MAX_ARCH_ORDER > 1) ? $clog2(MAX_ARCH_ORDER) : 1;
    localparam int GIW = (MAX_GARCH_ORDER > 1) ? $clog2(MAX_GARCH_ORDER) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARCH,
        S_ARCH_WAIT,
        S_GARCH,
        S_GARCH_WAIT,
        S_ROOT,
        S_ROOT_WAIT,
        S_RESID,
        S_RESID_WAIT,
        S_SQUARE,
        S_SQUARE_WAIT,
        S_DONE
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [gvp_pkg::ORDER_W-1:0] r_arch_order;
    logic [gvp_pkg::ORDER_W-1:0] r_garch_order;
    logic [WW-1:0]               r_alpha1;
    logic [WW-1:0]               r_alpha2;
    logic [WW-1:0]               r_beta1;
    logic [WW-1:0]               r_beta2;
    logic signed [DW-1:0]        r_mean;

    // Path state.
    logic [DW-1:0]               r_rsq_hist  [MAX_ARCH_ORDER];
    logic [DW-1:0]               r_seed_rsq  [MAX_ARCH_ORDER];
    logic [DW-1:0]               r_var_hist  [MAX_GARCH_ORDER];
    logic [AJW-1:0]              r_steps;

    // Working registers of the current step.
    logic [DW-1:0]               r_shock;
    logic [AW-1:0]               r_sum;
    logic [AJW-1:0]              r_aj;
    logic [GJW-1:0]              r_gj;
    logic [DW-1:0]               r_var;
    logic [gvp_pkg::SQ_ROOT_W-1:0] r_sigma;
    logic signed [DW-1:0]        r_resid;
    logic [DW-1:0]               r_mag;
    logic [DW-1:0]               r_rsq;

    logic                        r_out_valid;
    gvp_pkg::t_out_item          r_out;

    // Shared arithmetic units.
    logic                        n_mac_start;
    logic [DW-1:0]               n_mac_mcand;
    logic [DW-1:0]               n_mac_mplier;
    logic [AW-1:0]               n_mac_acc_in;
    logic                        w_mac_busy;
    logic [AW-1:0]               w_mac_acc;
    logic                        n_sq_start;
    logic                        w_sq_busy;
    logic [gvp_pkg::SQ_ROOT_W-1:0] w_sq_root;

    logic [AJW-1:0]              n_p;
    logic [GJW-1:0]              n_q;
    logic [DW-1:0]               n_arch_lag;
    logic [WW-1:0]               n_alpha;
    logic [WW-1:0]               n_beta;
    logic [DW-1:0]               n_var;
    logic [DW-1:0]               n_shock_mag;
    logic [AW-25:0]              n_prod;
    logic                        n_prod_big;
    logic signed [DW-1:0]        n_resid;
    logic [DW-1:0]               n_mag;
    logic [DW-1:0]               n_rsq;
    logic signed [DW:0]          n_series_wide;
    logic signed [DW-1:0]        n_series;
    logic                        w_in_acc;
    logic                        w_cfg_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;

    // Orders above the store depth are treated as the depth.
    always_comb begin
        if (int'(r_arch_order) > MAX_ARCH_ORDER) begin
            n_p = AJW'(MAX_ARCH_ORDER);
        end else begin
            n_p = AJW'(r_arch_order);
        end
        if (int'(r_garch_order) > MAX_GARCH_ORDER) begin
            n_q = GJW'(MAX_GARCH_ORDER);
        end else begin
            n_q = GJW'(r_garch_order);
        end
    end

    // Only the first two lags carry programmable weights; deeper lags weigh
    // zero. An ARCH lag reads its presample seed until enough steps have run.
    always_comb begin
        if (r_aj == AJW'(0)) begin
            n_alpha = r_alpha1;
        end else if (r_aj == AJW'(1)) begin
            n_alpha = r_alpha2;
        end else begin
            n_alpha = '0;
        end
        if (r_gj == GJW'(0)) begin
            n_beta = r_beta1;
        end else if (r_gj == GJW'(1)) begin
            n_beta = r_beta2;
        end else begin
            n_beta = '0;
        end
        if (r_steps <= r_aj) begin
            n_arch_lag = r_seed_rsq[r_aj[AIW-1:0]];
        end else begin
            n_arch_lag = r_rsq_hist[r_aj[AIW-1:0]];
        end
    end

    // The accumulator already holds the rounding half, so the variance is
    // its upper part, saturated to 32 bits.
    assign n_var = (|r_sum[AW-1:48]) ? '1 : r_sum[47:16];

    assign n_shock_mag = r_shock[DW-1] ? (~r_shock + 1'b1) : r_shock;

    // The product |shock| * sigma is in Q.40 with the half already added;
    // dropping 24 bits gives the rounded magnitude, then sign and saturate.
    assign n_prod     = w_mac_acc[AW-1:24];
    assign n_prod_big = |n_prod[AW-25:DW-1];

    always_comb begin
        if (n_prod_big) begin
            n_resid = r_shock[DW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            n_mag   = r_shock[DW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            n_resid = r_shock[DW-1] ? $signed(~n_prod[DW-1:0] + 1'b1)
                                    : $signed(n_prod[DW-1:0]);
            n_mag   = n_prod[DW-1:0];
        end
    end

    assign n_rsq = (|w_mac_acc[AW-1:48]) ? '1 : w_mac_acc[47:16];

    // Series: a 33-bit sum whose two top bits differ only on overflow.
    assign n_series_wide = {r_resid[DW-1], r_resid} + {r_mean[DW-1], r_mean};
    always_comb begin
        if (n_series_wide[DW] != n_series_wide[DW-1]) begin
            n_series = n_series_wide[DW] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            n_series = n_series_wide[DW-1:0];
        end
    end

    // Operand selection for the shared multiply-accumulate unit. The sum of
    // weighted lags is chained through it one lag at a time.
    always_comb begin
        n_mac_start  = 1'b0;
        n_mac_mcand  = n_arch_lag;
        n_mac_mplier = DW'(n_alpha);
        n_mac_acc_in = r_sum;
        n_sq_start   = 1'b0;
        case (r_state)
            S_ARCH: begin
                n_mac_start = (r_aj < n_p);
            end
            S_GARCH: begin
                n_mac_start  = (r_gj < n_q);
                n_mac_mcand  = r_var_hist[r_gj[GIW-1:0]];
                n_mac_mplier = DW'(n_beta);
            end
            S_ROOT: begin
                n_sq_start = 1'b1;
            end
            S_RESID: begin
                n_mac_start  = 1'b1;
                n_mac_mcand  = n_shock_mag;
                n_mac_mplier = DW'(r_sigma);
                n_mac_acc_in = gvp_pkg::RES_ROUND;
            end
            S_SQUARE: begin
                n_mac_start  = 1'b1;
                n_mac_mcand  = r_mag;
                n_mac_mplier = r_mag;
                n_mac_acc_in = gvp_pkg::SQR_ROUND;
            end
            default: begin
                n_mac_start = 1'b0;
            end
        endcase
    end

    gvp_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (n_mac_start),
        .i_mcand  (n_mac_mcand),
        .i_mplier (n_mac_mplier),
        .i_acc    (n_mac_acc_in),
        .o_busy   (w_mac_busy),
        .o_acc    (w_mac_acc)
    );

    gvp_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_sq_start),
        .i_radicand ({n_var, 16'h0000}),
        .o_busy     (w_sq_busy),
        .o_root     (w_sq_root)
    );

    // Register writes must arrive only while no request is in flight; the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arch_order  <= gvp_pkg::ORDER_W'(1);
            r_garch_order <= gvp_pkg::ORDER_W'(1);
            r_alpha1      <= '0;
            r_alpha2      <= '0;
            r_beta1       <= '0;
            r_beta2       <= '0;
            r_mean        <= '0;
        end else if (w_cfg_acc) begin
            case (gvp_pkg::t_cfg_index'(i_cfg_index))
                gvp_pkg::CFG_ARCH_ORDER:  r_arch_order  <= i_cfg_data[gvp_pkg::ORDER_W-1:0];
                gvp_pkg::CFG_GARCH_ORDER: r_garch_order <= i_cfg_data[gvp_pkg::ORDER_W-1:0];
                gvp_pkg::CFG_ALPHA_LAG1:  r_alpha1      <= i_cfg_data[WW-1:0];
                gvp_pkg::CFG_ALPHA_LAG2:  r_alpha2      <= i_cfg_data[WW-1:0];
                gvp_pkg::CFG_BETA_LAG1:   r_beta1       <= i_cfg_data[WW-1:0];
                gvp_pkg::CFG_BETA_LAG2:   r_beta2       <= i_cfg_data[WW-1:0];
                gvp_pkg::CFG_MEAN_LEVEL:  r_mean        <= $signed(i_cfg_data);
                default:                  r_mean        <= r_mean;
            endcase
        end
    end

    // Sequencer, path state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_steps     <= '0;
            for (int k = 0; k < MAX_ARCH_ORDER; k++) begin
                r_rsq_hist[k] <= '0;
                r_seed_rsq[k] <= '0;
            end
            for (int k = 0; k < MAX_GARCH_ORDER; k++) begin
                r_var_hist[k] <= '0;
            end
        end else begin
            // In the done state the hand-over below sets the valid flag itself.
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (gvp_pkg::t_cmd'(i_in.cmd) == gvp_pkg::CMD_STEP) begin
                            r_shock <= i_in.shock;
                            r_sum   <= {16'h0000, i_in.intercept, gvp_pkg::VAR_ROUND};
                            r_aj    <= '0;
                            r_gj    <= '0;
                            r_state <= S_ARCH;
                        end else begin
                            // A slot beyond a store's depth leaves that store alone.
                            for (int k = 0; k < MAX_ARCH_ORDER; k++) begin
                                if (k == int'(i_in.lag_slot)) begin
                                    r_seed_rsq[k] <= i_in.seed_residual_sq;
                                end
                            end
                            for (int k = 0; k < MAX_GARCH_ORDER; k++) begin
                                if (k == int'(i_in.lag_slot)) begin
                                    r_var_hist[k] <= i_in.seed_variance;
                                end
                            end
                            r_steps <= '0;
                        end
                    end
                end
                S_ARCH: begin
                    r_state <= (r_aj < n_p) ? S_ARCH_WAIT : S_GARCH;
                end
                S_ARCH_WAIT: begin
                    if (!w_mac_busy) begin
                        r_sum   <= w_mac_acc;
                        r_aj    <= r_aj + 1'b1;
                        r_state <= S_ARCH;
                    end
                end
                S_GARCH: begin
                    r_state <= (r_gj < n_q) ? S_GARCH_WAIT : S_ROOT;
                end
                S_GARCH_WAIT: begin
                    if (!w_mac_busy) begin
                        r_sum   <= w_mac_acc;
                        r_gj    <= r_gj + 1'b1;
                        r_state <= S_GARCH;
                    end
                end
                S_ROOT: begin
                    r_var   <= n_var;
                    r_state <= S_ROOT_WAIT;
                end
                S_ROOT_WAIT: begin
                    if (!w_sq_busy) begin
                        r_sigma <= w_sq_root;
                        r_state <= S_RESID;
                    end
                end
                S_RESID: begin
                    r_state <= S_RESID_WAIT;
                end
                S_RESID_WAIT: begin
                    if (!w_mac_busy) begin
                        r_resid <= n_resid;
                        r_mag   <= n_mag;
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    r_state <= S_SQUARE_WAIT;
                end
                S_SQUARE_WAIT: begin
                    if (!w_mac_busy) begin
                        r_rsq   <= n_rsq;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hand over once the output register is free or being taken.
                    if (!r_out_valid || i_out_ready) begin
                        r_out.variance <= r_var;
                        r_out.sigma    <= DW'(r_sigma);
                        r_out.residual <= r_resid;
                        r_out.series   <= n_series;
                        r_out_valid    <= 1'b1;
                        for (int k = MAX_ARCH_ORDER - 1; k > 0; k--) begin
                            r_rsq_hist[k] <= r_rsq_hist[k-1];
                        end
                        r_rsq_hist[0] <= r_rsq;
                        for (int k = MAX_GARCH_ORDER - 1; k > 0; k--) begin
                            r_var_hist[k] <= r_var_hist[k-1];
                        end
                        r_var_hist[0] <= r_var;
                        if (r_steps < AJW'(MAX_ARCH_ORDER)) begin
                            r_steps <= r_steps + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> rtl/gvp_mac.sv
`timescale 1ns / 1ps

// Multiply-accumulate that consumes the multiplier one digit per cycle,
// least significant digit first, and stops as soon as no digits remain.
module gvp_mac (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [gvp_pkg::DATA_W-1:0]       i_mcand,
    input  logic [gvp_pkg::DATA_W-1:0]       i_mplier,
    input  logic [gvp_pkg::MAC_ACC_W-1:0]    i_acc,
    output logic                             o_busy,
    output logic [gvp_pkg::MAC_ACC_W-1:0]    o_acc
);

    logic                             r_run;
    logic [gvp_pkg::MAC_ACC_W-1:0]    r_a;
    logic [gvp_pkg::DATA_W-1:0]       r_b;
    logic [gvp_pkg::MAC_ACC_W-1:0]    r_acc;
    logic [gvp_pkg::MAC_ACC_W-1:0]    n_pp;

    assign n_pp = r_a * gvp_pkg::MAC_ACC_W'(r_b[gvp_pkg::MAC_DIG_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_start) begin
            r_run <= 1'b1;
        end else if (r_run && (r_b == '0)) begin
            r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= gvp_pkg::MAC_ACC_W'(i_mcand);
            r_b   <= i_mplier;
            r_acc <= i_acc;
        end else if (r_run && (r_b != '0)) begin
            r_acc <= r_acc + n_pp;
            r_a   <= r_a << gvp_pkg::MAC_DIG_W;
            r_b   <= r_b >> gvp_pkg::MAC_DIG_W;
        end
    end

    assign o_busy = r_run;
    assign o_acc  = r_acc;

endmodule

>>> rtl/gvp_sqrt.sv
`timescale 1ns / 1ps

// Restoring square root: two radicand bits enter and one root bit leaves
// every cycle, so the root is the floor of the exact square root.
module gvp_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [gvp_pkg::SQ_IN_W-1:0]     i_radicand,
    output logic                            o_busy,
    output logic [gvp_pkg::SQ_ROOT_W-1:0]   o_root
);

    logic                            r_run;
    logic [gvp_pkg::SQ_CNT_W-1:0]    r_cnt;
    logic [gvp_pkg::SQ_IN_W-1:0]     r_rad;
    logic [gvp_pkg::SQ_REM_W-1:0]    r_rem;
    logic [gvp_pkg::SQ_ROOT_W-1:0]   r_root;
    logic [gvp_pkg::SQ_REM_W-1:0]    n_rem_sh;
    logic [gvp_pkg::SQ_REM_W-1:0]    n_trial;

    assign n_rem_sh = {r_rem[gvp_pkg::SQ_REM_W-3:0], r_rad[gvp_pkg::SQ_IN_W-1 -: 2]};
    assign n_trial  = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_cnt <= gvp_pkg::SQ_CNT_W'(gvp_pkg::SQ_ROOT_W);
        end else if (r_run) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == gvp_pkg::SQ_CNT_W'(1)) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_run) begin
            r_rad <= r_rad << 2;
            if (n_rem_sh >= n_trial) begin
                r_rem  <= n_rem_sh - n_trial;
                r_root <= {r_root[gvp_pkg::SQ_ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= n_rem_sh;
                r_root <= {r_root[gvp_pkg::SQ_ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_run;
    assign o_root = r_root;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

    // Number of lag slots the block is built with.
    localparam int ARCH_LAGS  = gvp_pkg::MAX_ARCH_ORDER_DEF;
    localparam int GARCH_LAGS = gvp_pkg::MAX_GARCH_ORDER_DEF;

    // The limit covers the long receiver hold-off below with a wide margin.
    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_CYCLES     = 300;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 117;

    // What a row of the opening script does: send a request and predict its
    // result, send a request whose result is written in the row, or write a
    // register. A register write carries its value in the intercept field.
    typedef enum logic [1:0] {
        SCRIPT_SEND,
        SCRIPT_KNOWN,
        SCRIPT_WRITE
    } t_script_op;

    typedef struct packed {
        t_script_op          op;
        gvp_pkg::t_cfg_index reg_idx;
        gvp_pkg::t_in_item   req;
        gvp_pkg::t_out_item  want;
    } t_script_row;

    // The opening script. The first five steps run with the reset settings
    // (all weights zero, mean zero), so their results follow from the
    // intercept and the shock alone. Then come the largest weights and the
    // largest seeds, so that the variance and the series saturate and the
    // second ARCH lag still reads its seed one step after the preload. Then
    // both orders go above the number of lags, and last both go to zero.
    localparam t_script_row SCRIPT [32] = '{
        '{SCRIPT_KNOWN, gvp_pkg::CFG_ARCH_ORDER,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0}, '0},
        '{SCRIPT_KNOWN, gvp_pkg::CFG_ARCH_ORDER,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h0100_0000, 32'h0001_0000},
          '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000}},
        '{SCRIPT_KNOWN, gvp_pkg::CFG_ARCH_ORDER,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'hFF00_0000, 32'h0001_0000},
          '{32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000}},
        '{SCRIPT_SEND, gvp_pkg::CFG_ARCH_ORDER,
          '{gvp_pkg::CMD_STEP, 1'b1, 32'h0, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF}, '0},
        '{SCRIPT_SEND, gvp_pkg::CFG_ARCH_ORDER,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, '0},
        '{SCRIPT_WRITE, gvp_pkg::CFG_MEAN_LEVEL,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF}, '0},
        '{SCRIPT_WRITE, gvp_pkg::CFG_ALPHA_LAG1,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0000_FFFF}, '0},
        '{SCRIPT_WRITE, gvp_pkg::CFG_ALPHA_LAG2,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0000_FFFF}, '0},
        '{SCRIPT_WRITE, gvp_pkg::CFG_BETA_LAG1,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0000_FFFF}, '0},
        '{SCRIPT_WRITE, gvp_pkg::CFG_BETA_LAG2,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0000_FFFF}, '0},
        '{SCRIPT_WRITE, gvp_pkg::CFG_ARCH_ORDER,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h2}, '0},
        '{SCRIPT_WRITE, gvp_pkg::CFG_GARCH_ORDER,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h2}, '0},
        '{SCRIPT_SEND, gvp_pkg::CFG_ARCH_ORDER,
          '{gvp_pkg::CMD_PRELOAD, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0}, '0},
        '{SCRIPT_SEND, gvp_pkg::CFG_ARCH_ORDER,
          '{gvp_pkg::CMD_PRELOAD, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0}, '0},
        '{SCRIPT_SEND, gvp_pkg::CFG_ARCH_ORDER,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0}, '0},
        '{SCRIPT_SEND, gvp_pkg::CFG_ARCH_ORDER,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h0080_0000, 32'h0}, '0},
        '{SCRIPT_SEND, gvp_pkg::CFG_ARCH_ORDER,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h0100_0000, 32'h0}, '0},
        '{SCRIPT_WRITE, gvp_pkg::CFG_ALPHA_LAG1,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0000_4000}, '0},
        '{SCRIPT_WRITE, gvp_pkg::CFG_ALPHA_LAG2,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0000_2000}, '0},
        '{SCRIPT_WRITE, gvp_pkg::CFG_BETA_LAG1,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0000_3000}, '0},
        '{SCRIPT_WRITE, gvp_pkg::CFG_BETA_LAG2,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0000_1000}, '0},
        '{SCRIPT_WRITE, gvp_pkg::CFG_MEAN_LEVEL,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h8000_0000}, '0},
        '{SCRIPT_WRITE, gvp_pkg::CFG_ARCH_ORDER,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h3}, '0},
        '{SCRIPT_WRITE, gvp_pkg::CFG_GARCH_ORDER,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h3}, '0},
        '{SCRIPT_SEND, gvp_pkg::CFG_ARCH_ORDER,
          '{gvp_pkg::CMD_PRELOAD, 1'b0, 32'h0003_0000, 32'h0002_0000, 32'h0, 32'h0}, '0},
        '{SCRIPT_SEND, gvp_pkg::CFG_ARCH_ORDER,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h8000_0000, 32'h0000_8000}, '0},
        '{SCRIPT_SEND, gvp_pkg::CFG_ARCH_ORDER,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'hFE80_0000, 32'h0001_0000}, '0},
        '{SCRIPT_SEND, gvp_pkg::CFG_ARCH_ORDER,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h0200_0000, 32'h0001_0000}, '0},
        '{SCRIPT_WRITE, gvp_pkg::CFG_ARCH_ORDER,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0}, '0},
        '{SCRIPT_WRITE, gvp_pkg::CFG_GARCH_ORDER,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0}, '0},
        '{SCRIPT_SEND, gvp_pkg::CFG_ARCH_ORDER,
          '{gvp_pkg::CMD_STEP, 1'b0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0004_0000}, '0},
        '{SCRIPT_SEND, gvp_pkg::CFG_ARCH_ORDER,
          '{gvp_pkg::CMD_STEP, 1'b1, 32'h0, 32'h0, 32'h0000_0001, 32'h0000_0001}, '0}
    };

    // Clock, reset and the three channels. Every input of the block starts
    // at a known value.
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    gvp_pkg::t_in_item   in_req    = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    gvp_pkg::t_out_item  out_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    gvp_pkg::t_cfg_index cfg_index = gvp_pkg::CFG_ARCH_ORDER;
    logic [31:0]         cfg_data  = '0;

    // Side information that travels with each request: whether its result
    // is written in the script, and if so what it is.
    logic               req_known = 1'b0;
    gvp_pkg::t_out_item req_want  = '0;

    wire in_fire  = in_valid && in_ready;
    wire out_fire = out_valid && out_ready;
    wire cfg_fire = cfg_valid && cfg_ready;

    // Pacing controls shared between the stimulus and the receiver.
    bit tx_quiet     = 1'b0;
    bit rx_quiet     = 1'b0;
    bit hold_request = 1'b0;

    // Results still owed by the block, oldest first.
    gvp_pkg::t_out_item expected_steps [$];
    int unsigned        n_bad = 0;

    // Predictor state: settings and the path history of the simulated
    // process.
    logic [1:0]         n_arch;
    logic [1:0]         n_garch;
    logic [15:0]        arch_wt      [ARCH_LAGS];
    logic [15:0]        garch_wt     [GARCH_LAGS];
    logic signed [31:0] mean_q16;
    logic [31:0]        sq_resid_lag [ARCH_LAGS];
    logic [31:0]        presample_sq [ARCH_LAGS];
    logic [31:0]        var_lag      [GARCH_LAGS];
    int unsigned        steps_since_seed;

    garch_variance_path_step i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic longint clamp_s32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Applies one request to the predicted path. A preload seeds a lag slot
    // and yields nothing. A step forms the variance from the intercept and
    // the weighted lags, takes its root, scales the shock by it, adds the
    // mean, and pushes the new squared residual and variance into the
    // histories.
    function automatic bit advance_path(input gvp_pkg::t_in_item req,
                                        output gvp_pkg::t_out_item r);
        logic [63:0] acc, mag, prod, root, cand, rad;
        logic [31:0] var_q, sq_q, lag_val;
        longint      resid, total;
        int unsigned na, ng;
        int          j;
        bit          neg;

        r = '0;
        if (req.cmd == gvp_pkg::CMD_PRELOAD) begin
            if (req.lag_slot < ARCH_LAGS) presample_sq[req.lag_slot] = req.seed_residual_sq;
            if (req.lag_slot < GARCH_LAGS) var_lag[req.lag_slot] = req.seed_variance;
            steps_since_seed = 0;
            return 1'b0;
        end

        // Orders beyond the number of built lags use all of them.
        na = (n_arch > ARCH_LAGS) ? ARCH_LAGS : n_arch;
        ng = (n_garch > GARCH_LAGS) ? GARCH_LAGS : n_garch;

        // The sum is exact in Q32.32 and rounded once at the end. ARCH lag j
        // still reads its seed until more than j steps have followed the
        // last preload.
        acc = {16'b0, req.intercept, 16'b0};
        for (j = 0; j < na; j++) begin
            lag_val = (steps_since_seed <= j) ? presample_sq[j] : sq_resid_lag[j];
            acc += 64'(arch_wt[j]) * 64'(lag_val);
        end
        for (j = 0; j < ng; j++)
            acc += 64'(garch_wt[j]) * 64'(var_lag[j]);
        acc = (acc + 64'h8000) >> 16;
        var_q = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];

        // Floor square root of the variance scaled by 2^16, built bit by bit
        // from the top; the root fits in 24 bits.
        rad = {16'b0, var_q, 16'b0};
        root = '0;
        for (j = 23; j >= 0; j--) begin
            cand = root | (64'd1 << j);
            if (cand * cand <= rad) root = cand;
        end

        // Magnitude times sigma, rounded half away from zero, then signed and
        // saturated.
        neg = req.shock[31];
        mag = neg ? (64'h1_0000_0000 - {32'b0, req.shock}) : {32'b0, req.shock};
        prod = (mag * root + 64'h80_0000) >> 24;
        if (prod > 64'h8000_0000) prod = 64'h8000_0000;
        resid = clamp_s32(neg ? -longint'(prod) : longint'(prod));

        mag = (resid < 0) ? 64'(-resid) : 64'(resid);
        prod = (mag * mag + 64'h8000) >> 16;
        sq_q = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];

        total = clamp_s32(resid + longint'(mean_q16));

        for (j = ARCH_LAGS - 1; j > 0; j--) sq_resid_lag[j] = sq_resid_lag[j - 1];
        sq_resid_lag[0] = sq_q;
        for (j = GARCH_LAGS - 1; j > 0; j--) var_lag[j] = var_lag[j - 1];
        var_lag[0] = var_q;
        if (steps_since_seed < ARCH_LAGS) steps_since_seed++;

        r.variance = var_q;
        r.sigma    = root[31:0];
        r.residual = 32'(resid);
        r.series   = 32'(total);
        return 1'b1;
    endfunction

    function automatic int unsigned draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, 16);
    endfunction

    // Q16.16 values: full range now and then, mostly modest magnitudes so
    // that the variance does not sit at its ceiling, and both extremes.
    function automatic logic [31:0] pick_q16();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0002_0000);
            2: return $urandom_range(0, 32'h0000_4000);
            default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        endcase
    endfunction

    function automatic logic [15:0] pick_weight(int unsigned phase);
        if (phase == 0) return 16'hFFFF;
        if (phase == 1) return 16'h0000;
        if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 16'hFFFF));
        return 16'($urandom_range(0, 16'h5000));
    endfunction

    // Mostly steps along a path, with a preload of a random slot now and
    // then to restart the seed window. Shocks are mostly within +/-4.0.
    function automatic gvp_pkg::t_in_item draw_request();
        gvp_pkg::t_in_item r;

        r.cmd              = ($urandom_range(0, 99) < 12) ? gvp_pkg::CMD_PRELOAD
                                                           : gvp_pkg::CMD_STEP;
        r.lag_slot         = 1'($urandom_range(0, 1));
        r.seed_residual_sq = pick_q16();
        r.seed_variance    = pick_q16();
        r.shock            = ($urandom_range(0, 3) == 0) ? $urandom
                           : 32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
        r.intercept        = pick_q16();
        return r;
    endfunction

    function automatic void note_mismatch(string msg);
        n_bad++;
        if (n_bad <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // Offers one request after a random gap and returns at the edge where
    // it is taken. Valid is only lowered when there is a gap, so that a
    // request that follows at once keeps valid high without a glitch.
    task automatic offer_request(input gvp_pkg::t_in_item req, input bit known,
                                 input gvp_pkg::t_out_item want);
        int unsigned gap;

        gap = draw_gap(tx_quiet);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_req    <= req;
        req_known <= known;
        req_want  <= want;
        do @(posedge clk); while (!in_fire);
    endtask

    // Brings the block to rest: no request offered, every result delivered,
    // and then waits on so that a trailing preload has landed.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_steps.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input gvp_pkg::t_cfg_index idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_fire);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Scoreboard. Results are checked before the request taken at the same
    // edge is predicted; the block holds one request at a time, so that
    // result always belongs to an earlier request.
    always @(posedge clk) begin : score
        gvp_pkg::t_out_item want;
        gvp_pkg::t_out_item predicted;
        int                 j;

        if (!rst_n) begin
            n_arch  = 2'd1;
            n_garch = 2'd1;
            mean_q16 = '0;
            for (j = 0; j < ARCH_LAGS; j++) begin
                arch_wt[j]      = '0;
                sq_resid_lag[j] = '0;
                presample_sq[j] = '0;
            end
            for (j = 0; j < GARCH_LAGS; j++) begin
                garch_wt[j] = '0;
                var_lag[j]  = '0;
            end
            steps_since_seed = 0;
        end else begin
            if (out_fire) begin
                if (expected_steps.size() == 0) begin
                    note_mismatch($sformatf("result %h arrived with none expected", out_item));
                end else begin
                    want = expected_steps.pop_front();
                    if (out_item.variance !== want.variance)
                        note_mismatch($sformatf("variance: expected %h, got %h",
                                                want.variance, out_item.variance));
                    if (out_item.sigma !== want.sigma)
                        note_mismatch($sformatf("sigma: expected %h, got %h",
                                                want.sigma, out_item.sigma));
                    if (out_item.residual !== want.residual)
                        note_mismatch($sformatf("residual: expected %h, got %h",
                                                want.residual, out_item.residual));
                    if (out_item.series !== want.series)
                        note_mismatch($sformatf("series: expected %h, got %h",
                                                want.series, out_item.series));
                end
            end
            if (in_fire) begin
                if (advance_path(in_req, predicted))
                    expected_steps.push_back(req_known ? req_want : predicted);
            end
            if (cfg_fire) begin
                case (cfg_index)
                    gvp_pkg::CFG_ARCH_ORDER:  n_arch      = cfg_data[1:0];
                    gvp_pkg::CFG_GARCH_ORDER: n_garch     = cfg_data[1:0];
                    gvp_pkg::CFG_ALPHA_LAG1:  arch_wt[0]  = cfg_data[15:0];
                    gvp_pkg::CFG_ALPHA_LAG2:  arch_wt[1]  = cfg_data[15:0];
                    gvp_pkg::CFG_BETA_LAG1:   garch_wt[0] = cfg_data[15:0];
                    gvp_pkg::CFG_BETA_LAG2:   garch_wt[1] = cfg_data[15:0];
                    gvp_pkg::CFG_MEAN_LEVEL:  mean_q16    = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Result receiver. Before each result it stalls for a random number of
    // cycles. When asked for a hold-off it keeps ready low for a long
    // stretch instead, so that the block fills up and refuses new requests.
    initial begin : drain_results
        int unsigned gap;

        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                gap = draw_gap(rx_quiet);
                if (gap > 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_fire);
        end
    end

    // Ends the run when no channel has moved anything for too long.
    initial begin : watchdog
        int unsigned quiet;

        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (in_fire || out_fire || cfg_fire) quiet = 0;
            else quiet++;
        end
        $display("garch_variance_path_step: mismatch");
        $finish;
    end

    // Main sequence: reset, the opening script, then random phases. Each
    // phase starts from rest and rewrites every register. The first phase
    // sets every register to its top value and the second to its bottom;
    // the rest are random. One phase runs without gaps on either side, and
    // another opens with the long receiver hold-off.
    initial begin : run
        int unsigned phase;
        int          k;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < $size(SCRIPT); k++) begin
            if (SCRIPT[k].op == SCRIPT_WRITE) begin
                settle();
                write_reg(SCRIPT[k].reg_idx, SCRIPT[k].req.intercept);
            end else begin
                offer_request(SCRIPT[k].req, SCRIPT[k].op == SCRIPT_KNOWN, SCRIPT[k].want);
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            tx_quiet = (phase == 5);
            rx_quiet = (phase == 5);
            write_reg(gvp_pkg::CFG_ARCH_ORDER,
                      phase == 0 ? 32'd3 : phase == 1 ? 32'd0 : $urandom_range(0, 3));
            write_reg(gvp_pkg::CFG_GARCH_ORDER,
                      phase == 0 ? 32'd3 : phase == 1 ? 32'd0 : $urandom_range(0, 3));
            write_reg(gvp_pkg::CFG_ALPHA_LAG1, 32'(pick_weight(phase)));
            write_reg(gvp_pkg::CFG_ALPHA_LAG2, 32'(pick_weight(phase)));
            write_reg(gvp_pkg::CFG_BETA_LAG1, 32'(pick_weight(phase)));
            write_reg(gvp_pkg::CFG_BETA_LAG2, 32'(pick_weight(phase)));
            write_reg(gvp_pkg::CFG_MEAN_LEVEL,
                      phase == 0 ? 32'h7FFF_FFFF : phase == 1 ? 32'h8000_0000
                      : $urandom_range(0, 1) ? $urandom
                      : 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000);
            if (phase == 2) hold_request = 1'b1;
            repeat (ITEMS_PER_PHASE) offer_request(draw_request(), 1'b0, '0);
        end

        // Let every owed result come out, then watch a while longer for
        // anything extra.
        settle();
        repeat (100) @(posedge clk);
        if (n_bad == 0 && expected_steps.size() == 0) begin
            $display("garch_variance_path_step: match");
        end else begin
            $display("garch_variance_path_step: mismatch");
        end
        $finish;
    end

endmodule
